// ===== hdl/cmrb_pkg.sv =====
package cmrb_pkg;

    localparam int STATE_BITS = 32;
    localparam int FRAC_BITS  = 28;
    localparam int SKIP_BITS  = 16;
    localparam int BYTE_BITS  = 8;
    localparam int BCNT_BITS  = 3;

    localparam logic [63:0] HALF_WIDE = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] ONE_WIDE  = 64'd1 << FRAC_BITS;

    localparam logic [STATE_BITS-1:0] MAP_HALF = HALF_WIDE[STATE_BITS-1:0];
    localparam logic [STATE_BITS-1:0] MAP_ONE  = ONE_WIDE[STATE_BITS-1:0];

    localparam logic [BCNT_BITS-1:0] LAST_BIT = {BCNT_BITS{1'b1}};

    typedef logic [STATE_BITS-1:0] map_t;
    typedef logic [SKIP_BITS-1:0]  skip_t;
    typedef logic [BYTE_BITS-1:0]  byte_t;
    typedef logic [BCNT_BITS-1:0]  bcnt_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

// ===== hdl/cmrb_tick_if.sv =====
interface cmrb_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// ===== hdl/cmrb_byte_if.sv =====
interface cmrb_byte_if
    import cmrb_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t random_byte;

    modport source (output valid, output random_byte, input ready);
    modport sink   (input valid, input random_byte, output ready);
endinterface

// ===== hdl/cmrb_cfg_if.sv =====
interface cmrb_cfg_if
    import cmrb_pkg::*;
;
    logic  valid;
    logic  ready;
    skip_t skip_count;

    modport source (output valid, output skip_count, input ready);
    modport sink   (input valid, input skip_count, output ready);
endinterface

// ===== hdl/chaotic_map_random_bytes.sv =====
// Random byte generator driven by the piecewise linear chaotic map
// x' = 1.875x + 1 (x negative) or 1.875x - 1 (otherwise), evaluated as 2x - x/8 in
// STATE_BITS-bit two's complement with FRAC_BITS fraction bits. Each tick item with
// restart low runs skip_count discarded iterations, then records the sign bit of the
// map value (MSB first) and iterates once more; every eighth recorded bit releases one
// byte on the output channel. A tick with restart high reloads x = 0.5, clears the
// partial byte and yields nothing. A single map-update unit does one iteration per
// cycle. With skip_count at zero a tick is taken every cycle; otherwise an advancing
// tick enters the run state, and the input is held off while the discarded iterations
// and the recording iteration are done. A finished byte waits in an output register
// while further ticks are taken. While it is still there and the partial byte lacks
// only one bit, the input is held off when skip_count is zero; otherwise the tick is
// taken but its recording iteration waits. skip_count is written through the
// configuration channel, which is always ready, and resets to zero.
module chaotic_map_random_bytes
    import cmrb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cmrb_cfg_if.sink      cfg,
    cmrb_tick_if.sink     tick,
    cmrb_byte_if.source   rnd
);

    state_t state_reg, state_next;
    skip_t  skip_reg;
    skip_t  cnt_reg, cnt_next;
    map_t   x_reg, x_next;
    bcnt_t  bits_reg, bits_next;
    byte_t  acc_reg, acc_next;
    logic   out_valid_reg, out_valid_next;
    byte_t  out_data_reg, out_data_next;

    logic   out_free;
    logic   tick_fire;
    logic   x_neg;
    map_t   x_iter;
    byte_t  acc_bit;
    logic   do_bit;

    assign out_free  = !out_valid_reg || rnd.ready;
    assign x_neg     = x_reg[STATE_BITS-1];
    assign x_iter    = (x_reg << 1) - map_t'($signed(x_reg) >>> 3)
                       + (x_neg ? MAP_ONE : -MAP_ONE);
    assign acc_bit   = acc_reg | (byte_t'(x_neg) << (LAST_BIT - bits_reg));

    assign cfg.ready = 1'b1;
    assign tick.ready = (state_reg == ST_IDLE)
                        && (bits_reg != LAST_BIT || skip_reg != '0 || out_free);
    assign tick_fire = tick.valid && tick.ready;

    assign rnd.valid       = out_valid_reg;
    assign rnd.random_byte = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        bits_next      = bits_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !rnd.ready;
        out_data_next  = out_data_reg;
        do_bit         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (tick_fire)
                begin
                    if (tick.restart)
                    begin
                        x_next    = MAP_HALF;
                        bits_next = '0;
                        acc_next  = '0;
                    end
                    else if (skip_reg == '0)
                    begin
                        do_bit = 1'b1;
                    end
                    else
                    begin
                        cnt_next   = skip_reg;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (cnt_reg != '0)
                begin
                    x_next   = x_iter;
                    cnt_next = cnt_reg - skip_t'(1);
                end
                else if (bits_reg != LAST_BIT || out_free)
                begin
                    do_bit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_bit)
        begin
            x_next = x_iter;
            if (bits_reg == LAST_BIT)
            begin
                out_valid_next = 1'b1;
                out_data_next  = acc_bit;
                acc_next       = '0;
                bits_next      = '0;
            end
            else
            begin
                acc_next  = acc_bit;
                bits_next = bits_reg + bcnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            skip_reg      <= '0;
            cnt_reg       <= '0;
            x_reg         <= MAP_HALF;
            bits_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            x_reg         <= x_next;
            bits_reg      <= bits_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                skip_reg <= cfg.skip_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import cmrb_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    cmrb_cfg_if  cfg_ch ();
    cmrb_tick_if tick_ch ();
    cmrb_byte_if rnd_ch ();

    chaotic_map_random_bytes u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .tick  (tick_ch),
        .rnd   (rnd_ch)
    );

    map_t  map_now;
    bcnt_t bits_now;
    byte_t acc_now;
    skip_t skip_now;
    logic  tail_busy;
    byte_t bytes_due[$];

    int   errors = 0;
    logic tx_steady;
    logic rx_steady;
    int   hold_reqs;
    int   hold_seen;
    int   hold_left;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic map_t map_step(input map_t x);
        map_t eighth;
        map_t y;
        eighth = {{3{x[STATE_BITS-1]}}, x[STATE_BITS-1:3]};
        y = (x << 1) - eighth;
        if (x[STATE_BITS-1])
            return y + MAP_ONE;
        return y - MAP_ONE;
    endfunction

    function automatic void predict_tick(input logic rs);
        int unsigned n;
        logic sign_bit;
        if (rs)
        begin
            map_now   = MAP_HALF;
            bits_now  = '0;
            acc_now   = '0;
            tail_busy = 1'b1;
            return;
        end
        for (n = 0; n < skip_now; n++)
            map_now = map_step(map_now);
        sign_bit = map_now[STATE_BITS-1];
        map_now  = map_step(map_now);
        if (sign_bit)
            acc_now[BYTE_BITS-1-bits_now] = 1'b1;
        if (bits_now == LAST_BIT)
        begin
            bytes_due.push_back(acc_now);
            acc_now   = '0;
            bits_now  = '0;
            tail_busy = 1'b0;
        end
        else
        begin
            bits_now  = bits_now + 1'b1;
            tail_busy = 1'b1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_seen    <= 0;
        end
        else
        begin
            if (rnd_ch.valid && rnd_ch.ready)
            begin
                if (bytes_due.size() == 0)
                begin
                    $error("random_byte expected none got %02h", rnd_ch.random_byte);
                    errors++;
                end
                else
                begin
                    if (rnd_ch.random_byte !== bytes_due[0])
                    begin
                        $error("random_byte expected %02h got %02h",
                               bytes_due[0], rnd_ch.random_byte);
                        errors++;
                    end
                    void'(bytes_due.pop_front());
                end
            end
            if (hold_seen != hold_reqs)
            begin
                hold_seen    <= hold_reqs;
                hold_left    <= HOLD_CYCLES;
                rnd_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                rnd_ch.ready <= 1'b0;
            end
            else
                rnd_ch.ready <= rx_steady || ($urandom_range(0, 99) >= 37);
        end
    end

    task automatic send_tick(input logic rs);
        if (!tx_steady)
            while ($urandom_range(0, 99) < 37)
            begin
                tick_ch.valid   <= 1'b0;
                tick_ch.restart <= 1'($urandom_range(0, 1));
                @(posedge clk);
            end
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= rs;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        predict_tick(rs);
    endtask

    task automatic settle_block();
        tick_ch.valid <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (tail_busy ? skip_now + 8 : 8) @(posedge clk);
    endtask

    task automatic write_skip(input skip_t value);
        settle_block();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.skip_count <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        skip_now = value;
    endtask

    task automatic test_restart_mid_byte();
        repeat (3) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        repeat (8) send_tick(1'b0);
    endtask

    task automatic test_skip_extremes();
        write_skip(skip_t'('1));
        repeat (8) send_tick(1'b0);
        write_skip('0);
    endtask

    task automatic test_random_phases();
        skip_t plan[7];
        int p;
        plan = '{skip_t'(0), skip_t'(1), skip_t'(5), skip_t'($urandom_range(0, 15)),
                 skip_t'($urandom_range(16, 300)), skip_t'(2), skip_t'(0)};
        for (p = 0; p < 7; p++)
        begin
            write_skip(plan[p]);
            tx_steady = (p == 3);
            rx_steady = (p == 3);
            repeat (100) send_tick($urandom_range(0, 19) == 0);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_output_stall();
        write_skip('0);
        hold_reqs <= hold_reqs + 1;
        tx_steady = 1'b1;
        repeat (64) send_tick(1'b0);
        tx_steady = 1'b0;
    endtask

    initial
    begin
        #(4 * 3_000_000);
        $display("[chaotic_map_random_bytes] ERROR");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        tick_ch.valid     = 1'b0;
        tick_ch.restart   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.skip_count = '0;
        tx_steady         = 1'b0;
        rx_steady         = 1'b0;
        hold_reqs         = 0;
        map_now           = MAP_HALF;
        bits_now          = '0;
        acc_now           = '0;
        skip_now          = '0;
        tail_busy         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_restart_mid_byte();
        test_skip_extremes();
        test_random_phases();
        test_output_stall();

        settle_block();
        if (errors == 0)
            $display("[chaotic_map_random_bytes] OK");
        else
            $display("[chaotic_map_random_bytes] ERROR");
        $finish;
    end
endmodule

// ===== chaotic_map_random_bytes.f =====
hdl/cmrb_pkg.sv
hdl/cmrb_tick_if.sv
hdl/cmrb_byte_if.sv
hdl/cmrb_cfg_if.sv
hdl/chaotic_map_random_bytes.sv
tb/tb.sv
